// File: rtl/keyed_rate_limiter_with_backoff_assert.svh
// Assertion macros for the keyed rate limiter.
// Included by the RTL top level, which carries the assertions.
`ifndef KEYED_RATE_LIMITER_WITH_BACKOFF_ASSERT_SVH
`define KEYED_RATE_LIMITER_WITH_BACKOFF_ASSERT_SVH
`ifndef SYNTHESIS
`define KRL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define KRL_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define KRL_ASSERT(label, clk, rst_n, prop)
`define KRL_ASSERT_RST(label, clk, prop)
`endif
`endif

// File: rtl/krl_pkg.sv
// Package for the keyed rate limiter: state codes, register indexes, entry type.
// No dependencies.
`default_nettype none
package krl_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_BASE  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BAN   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BANST = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DECAY = 3'd4;

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [7:0]  bucket;
    logic [31:0] wbegin;
    logic [16:0] tally;
    logic [7:0]  strikes;
    logic [31:0] blk_end;
  } entry_t;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_FETCH = 6'b001000,
    ST_UPD   = 6'b010000,
    ST_BLOCK = 6'b100000
  } state_e;
endpackage
`default_nettype wire

// File: rtl/keyed_rate_limiter_with_backoff.sv
// Keyed fixed-window rate limiter with strike backoff, top level.
// Depends on krl_pkg and keyed_rate_limiter_with_backoff_assert.svh.
//
// Usage: requests enter on s_axis (tdata = client_key, bucket_id,
// request_limit, window_length, now_seconds from bit 0 up); one verdict per
// request leaves on m_axis (tdata = allowed, newly_blocked, strike_level,
// untracked from bit 0 up). Configuration is written through cfg_we_i with
// cfg_idx_i/cfg_data_i; the user must do it only while idle (not enforced).
// A zero-limit request skips the scan and gives its verdict from the fetch
// step. Otherwise the entry memory is scanned one entry per cycle; when
// every entry is valid, stale entries are dropped in the same pass. A fetch,
// an update and a write-back follow; an untracked request gives its verdict
// from the fetch. One request is in flight at a time; the next is taken
// only once the verdict of the last has gone to the output register.
// Reset clears the registers and then runs a clearing pass over every entry
// of the entry memory; s_axis_tready stays low until it is done.
// A stalled verdict holds in the output register; the next request is still
// taken and processed, and its last step waits until the register is free.
`default_nettype none
`include "keyed_rate_limiter_with_backoff_assert.svh"
module keyed_rate_limiter_with_backoff import krl_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // key[63:0], bucket[71:64], limit[87:72], window[119:88], now[151:120]
  input  wire logic [151:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // allowed[0], newly_blocked[1], strike_level[9:2], untracked[10], zeros
  output logic [15:0]       m_axis_tdata
);
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW:0] NUM  = (AW+1)'(TABLE_ENTRIES);
  localparam logic [AW:0] LAST = (AW+1)'(TABLE_ENTRIES - 1);

  logic [15:0] base_q;
  logic [31:0] max_q, ban_q, decay_q;
  logic [4:0]  banst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 16'd60; max_q <= 32'd3600; ban_q <= 32'd86400;
      banst_q <= 5'd5; decay_q <= 32'd3600;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE:  base_q  <= cfg_data_i[15:0];
        CFG_MAX:   max_q   <= cfg_data_i;
        CFG_BAN:   ban_q   <= cfg_data_i;
        CFG_BANST: banst_q <= cfg_data_i[4:0];
        CFG_DECAY: decay_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  entry_t        mem [TABLE_ENTRIES];
  logic [AW-1:0] raddr;
  logic          mwe;
  logic [AW-1:0] maddr;
  entry_t        mwdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (mwe) mem[maddr] <= mwdata;
    rdata_q <= mem[raddr];
  end

  state_e        state_q, state_d;
  logic [151:0]  req_q;
  logic [AW:0]   cnt_q;
  logic [AW-1:0] rd_q;
  logic          pv_q;
  logic [AW:0]   used_q;
  logic          sweep_q, found_q, hasfree_q, fresh_q;
  logic [AW-1:0] slot_q, free_q;
  entry_t        ent_q;
  logic          tover_q, blkd_q;
  logic [15:0]   out_q, out_d;
  logic          ovld_q;
  logic          produce;

  entry_t        ent, e1, wb;
  logic          blkd, tover;
  logic [7:0]    stk;
  logic [47:0]   shl;
  logic [32:0]   blk;
  logic [32:0]   untl;

  wire [63:0] rkey = req_q[63:0];
  wire [7:0]  rbkt = req_q[71:64];
  wire [15:0] rlim = req_q[87:72];
  wire [31:0] rwin = req_q[119:88];
  wire [31:0] rnow = req_q[151:120];

  wire out_free = !ovld_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = out_q;

  // during the scan, entry rd_q arrives in rdata_q in the cycle after its read
  wire stale = (rnow >= rdata_q.blk_end) &&
               ($signed({1'b0, rnow}) - $signed({1'b0, rdata_q.wbegin})
                >= $signed({1'b0, decay_q}));
  wire drop     = pv_q && sweep_q && rdata_q.valid && stale;
  wire live     = rdata_q.valid && !drop;
  wire hit      = live && (rdata_q.key == rkey) && (rdata_q.bucket == rbkt);
  wire scan_end = (cnt_q == NUM);

  // update of the chosen entry
  always_comb begin
    ent = rdata_q;
    if (fresh_q) begin
      ent = '0;
      ent.valid = 1'b1; ent.key = rkey; ent.bucket = rbkt;
    end
    blkd = rnow < ent.blk_end;
    e1 = ent;
    tover = 1'b0;
    if (!blkd) begin
      if (e1.blk_end != 32'd0 &&
          (({1'b0, rnow} - {1'b0, e1.blk_end}) >= {1'b0, decay_q})) begin
        e1.strikes = '0; e1.blk_end = '0;
      end
      if ($signed({1'b0, rnow}) - $signed({1'b0, e1.wbegin}) >= $signed({1'b0, rwin})) begin
        e1.wbegin = rnow; e1.tally = '0;
      end
      e1.tally = e1.tally + 17'd1;
      tover = e1.tally > {1'b0, rlim};
      if (tover && e1.strikes != 8'hFF) e1.strikes = e1.strikes + 8'd1;
    end
  end

  // block length and write-back entry
  always_comb begin
    stk = ent_q.strikes;
    shl = {32'd0, base_q} << (stk[4:0] - 5'd1);
    if ({3'd0, banst_q} > stk) begin
      blk = (shl > {16'd0, max_q}) ? {1'b0, max_q} : shl[32:0];
    end else begin
      blk = {1'b0, ban_q};
    end
    untl = {1'b0, rnow} + blk;
    wb = ent_q;
    if (tover_q) begin
      wb.blk_end = untl[32] ? 32'hFFFF_FFFF : untl[31:0];
      wb.wbegin = rnow; wb.tally = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    raddr = slot_q;
    mwe = 1'b0; maddr = slot_q; mwdata = wb;
    produce = 1'b0; out_d = out_q;
    case (state_q)
      ST_CLEAR: begin
        mwe = 1'b1; maddr = cnt_q[AW-1:0]; mwdata = '0;
        if (cnt_q == LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = (s_axis_tdata[87:72] == 16'd0) ? ST_FETCH : ST_SCAN;
      end
      ST_SCAN: begin
        raddr = cnt_q[AW-1:0];
        if (drop) begin
          mwe = 1'b1; maddr = rd_q; mwdata = rdata_q; mwdata.valid = 1'b0;
        end
        if (scan_end) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        if (rlim != 16'd0 && (found_q || hasfree_q)) begin
          state_d = ST_UPD;
        end else if (out_free) begin
          produce = 1'b1;
          out_d = {5'd0, (rlim != 16'd0), 8'd0, 1'b0, 1'b1};
          state_d = ST_IDLE;
        end
      end
      ST_UPD: state_d = ST_BLOCK;
      ST_BLOCK: begin
        if (out_free) begin
          mwe = 1'b1; produce = 1'b1;
          out_d = {5'd0, 1'b0, ent_q.strikes, tover_q, !blkd_q && !tover_q};
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; cnt_q <= '0; used_q <= '0; ovld_q <= 1'b0; pv_q <= 1'b0;
      found_q <= 1'b0; hasfree_q <= 1'b0; sweep_q <= 1'b0; fresh_q <= 1'b0;
      req_q <= '0; rd_q <= '0; slot_q <= '0; free_q <= '0;
      ent_q <= '0; tover_q <= 1'b0; blkd_q <= 1'b0; out_q <= '0;
    end else begin
      state_q <= state_d;
      if (produce) begin
        ovld_q <= 1'b1; out_q <= out_d;
      end else if (m_axis_tready) begin
        ovld_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: cnt_q <= cnt_q + 1'b1;
        ST_IDLE: if (s_axis_tvalid) begin
          req_q <= s_axis_tdata; cnt_q <= '0; pv_q <= 1'b0;
          found_q <= 1'b0; hasfree_q <= 1'b0;
          sweep_q <= (used_q == NUM);
        end
        ST_SCAN: begin
          pv_q <= !scan_end;
          rd_q <= cnt_q[AW-1:0];
          cnt_q <= cnt_q + 1'b1;
          if (drop) used_q <= used_q - 1'b1;
          if (pv_q) begin
            if (hit && !found_q) begin
              found_q <= 1'b1; slot_q <= rd_q;
            end
            if (!live && !hasfree_q) begin
              hasfree_q <= 1'b1; free_q <= rd_q;
            end
          end
        end
        ST_FETCH: begin
          fresh_q <= !found_q;
          if (rlim != 16'd0 && !found_q && hasfree_q) begin
            slot_q <= free_q; used_q <= used_q + 1'b1;
          end
        end
        ST_UPD: begin
          ent_q <= e1; tover_q <= tover; blkd_q <= blkd;
        end
        default: ;
      endcase
    end
  end

  `KRL_ASSERT(a_out_hold, clk_i, rst_ni, (ovld_q && !m_axis_tready) |=> (ovld_q && $stable(out_q)))
  `KRL_ASSERT(a_one_busy, clk_i, rst_ni, (state_q != ST_IDLE) |-> !s_axis_tready)
  `KRL_ASSERT(a_used_max, clk_i, rst_ni, used_q <= NUM)
  `KRL_ASSERT(a_state_hot, clk_i, rst_ni, $onehot(state_q))
endmodule
`default_nettype wire

// File: tb/tb_keyed_rate_limiter_with_backoff.sv
// Testbench for keyed_rate_limiter_with_backoff: drives requests over the stream
// port, predicts each verdict with a local rate-limit table and compares beats.
// Depends on krl_pkg and the RTL top level.
`default_nettype none
module tb_keyed_rate_limiter_with_backoff import krl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumEntries = 256;

  typedef struct packed {
    logic        allowed;
    logic        newly_blocked;
    logic [7:0]  strike_level;
    logic        untracked;
  } verdict_t;

  int unsigned mismatch_count = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  class limiter_scoreboard;
    logic [15:0] base_s;
    logic [31:0] max_s;
    logic [31:0] ban_s;
    logic [4:0]  ban_cnt;
    logic [31:0] decay_s;
    bit          used[NumEntries];
    entry_t      tbl[NumEntries];
    verdict_t    pending_verdicts[$];

    function void clear();
      base_s = 16'd60;
      max_s = 32'd3600;
      ban_s = 32'd86400;
      ban_cnt = 5'd5;
      decay_s = 32'd3600;
      foreach (used[i]) used[i] = 1'b0;
      pending_verdicts.delete();
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        CFG_BASE:  base_s = val[15:0];
        CFG_MAX:   max_s = val;
        CFG_BAN:   ban_s = val;
        CFG_BANST: ban_cnt = val[4:0];
        CFG_DECAY: decay_s = val;
        default: ;
      endcase
    endfunction

    function void note_request(logic [151:0] req);
      logic [63:0] key;
      logic [7:0]  bkt;
      logic [15:0] lim;
      logic [31:0] win;
      logic [31:0] now;
      int          cnt;
      int          slot;
      int          free_slot;
      verdict_t    v;
      logic [63:0] blk;
      logic [63:0] till;
      key = req[63:0];
      bkt = req[71:64];
      lim = req[87:72];
      win = req[119:88];
      now = req[151:120];
      v = '{allowed: 1'b1, newly_blocked: 1'b0, strike_level: 8'd0, untracked: 1'b0};
      if (lim != 0) begin
        cnt = 0;
        foreach (used[i]) if (used[i]) cnt++;
        if (cnt >= NumEntries) begin
          foreach (used[i]) begin
            if (used[i] && now >= tbl[i].blk_end &&
                $signed({32'd0, now}) - $signed({32'd0, tbl[i].wbegin})
                  >= $signed({32'd0, decay_s}))
              used[i] = 1'b0;
          end
        end
        slot = -1;
        free_slot = -1;
        for (int i = 0; i < NumEntries; i++) begin
          if (used[i]) begin
            if (slot < 0 && tbl[i].key == key && tbl[i].bucket == bkt) slot = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (slot < 0 && free_slot < 0) begin
          v.untracked = 1'b1;
        end else begin
          if (slot < 0) begin
            slot = free_slot;
            used[slot] = 1'b1;
            tbl[slot] = '{key: key, bucket: bkt, default: '0};
          end
          if (now < tbl[slot].blk_end) begin
            v.allowed = 1'b0;
            v.strike_level = tbl[slot].strikes;
          end else begin
            if (tbl[slot].blk_end != 0 && {32'd0, now} >= {32'd0, tbl[slot].blk_end} +
                {32'd0, decay_s}) begin
              tbl[slot].strikes = '0;
              tbl[slot].blk_end = '0;
            end
            if ($signed({32'd0, now}) - $signed({32'd0, tbl[slot].wbegin})
                >= $signed({32'd0, win})) begin
              tbl[slot].wbegin = now;
              tbl[slot].tally = '0;
            end
            tbl[slot].tally = tbl[slot].tally + 17'd1;
            if (tbl[slot].tally <= {1'b0, lim}) begin
              v.strike_level = tbl[slot].strikes;
            end else begin
              if (tbl[slot].strikes != 8'd255) tbl[slot].strikes++;
              blk = {32'd0, ban_s};
              if ({3'd0, tbl[slot].strikes} < {3'd0, ban_cnt}) begin
                blk = {48'd0, base_s} << (tbl[slot].strikes - 8'd1);
                if (blk > {32'd0, max_s}) blk = {32'd0, max_s};
              end
              till = {32'd0, now} + blk;
              if (till > 64'hFFFF_FFFF) till = 64'hFFFF_FFFF;
              tbl[slot].blk_end = till[31:0];
              tbl[slot].wbegin = now;
              tbl[slot].tally = '0;
              v.allowed = 1'b0;
              v.newly_blocked = 1'b1;
              v.strike_level = tbl[slot].strikes;
            end
          end
        end
      end
      pending_verdicts.push_back(v);
    endfunction

    task check_verdict(logic [15:0] beat);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected beat", beat, 0);
        return;
      end
      want = pending_verdicts.pop_front();
      if (beat[0] !== want.allowed) report_mismatch("allowed", beat[0], want.allowed);
      if (beat[1] !== want.newly_blocked)
        report_mismatch("newly_blocked", beat[1], want.newly_blocked);
      if (beat[9:2] !== want.strike_level)
        report_mismatch("strike_level", beat[9:2], want.strike_level);
      if (beat[10] !== want.untracked) report_mismatch("untracked", beat[10], want.untracked);
      if (beat[15:11] !== 5'd0) report_mismatch("pad bits", beat[15:11], 0);
    endtask
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // key, bucket, limit, window, now
  logic [151:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // allowed, newly_blocked, strike_level, untracked, zeros
  logic [15:0]  m_axis_tdata;

  limiter_scoreboard limits = new();
  logic [31:0] clock_now = 0;
  bit          calm_phase = 1'b0;
  int unsigned hold_off_cycles = 0;

  always #5ns clk_i = ~clk_i;

  keyed_rate_limiter_with_backoff i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) limits.check_verdict(m_axis_tdata);
    if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm_phase || ($urandom_range(99) >= 22);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    limits.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (limits.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (NumEntries * 2 + 20) @(posedge clk_i);
  endtask

  task automatic send_request(input logic [63:0] key, input logic [7:0] bkt,
                              input logic [15:0] lim, input logic [31:0] win,
                              input logic [31:0] now);
    while (!calm_phase && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {now, win, lim, bkt, key};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    limits.note_request({now, win, lim, bkt, key});
  endtask

  task automatic random_phase(input int unsigned count, input int unsigned nkeys,
                              input int unsigned max_step);
    logic [63:0] key;
    logic [15:0] lim;
    for (int n = 0; n < count; n++) begin
      clock_now = clock_now + $urandom_range(max_step);
      key = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                     : 64'hA5A5_0000_0000_0000 + $urandom_range(nkeys - 1);
      lim = ($urandom_range(19) == 0) ? 16'd0 :
            ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4));
      send_request(key, 8'($urandom_range(2)), lim,
                   ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(0, 8)),
                   ($urandom_range(30) == 0) ? clock_now - 5 : clock_now);
    end
  endtask

  initial begin
    limits.clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed cases of unlimited, extremes, window resets, blocks, saturation
    send_request(64'd0, 8'd0, 16'd0, 32'd0, 32'd0);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
    for (int i = 0; i < 14; i++) send_request(64'h1234, 8'h5A, 16'd1, 32'd0, 32'd10 + i * 200);
    send_request(64'h1234, 8'h5A, 16'd1, 32'd0, 32'd9);
    send_request(64'h99, 8'h1, 16'd1, 32'd5, 32'hFFFF_FFF0);
    send_request(64'h99, 8'h1, 16'd1, 32'd5, 32'hFFFF_FFF1);
    send_request(64'h99, 8'h1, 16'd1, 32'd5, 32'hFFFF_FFFF);
    drain();
    write_reg(CFG_BASE, 32'd1);
    write_reg(CFG_MAX, 32'd4);
    write_reg(CFG_BAN, 32'd20);
    write_reg(CFG_BANST, 32'd16);
    write_reg(CFG_DECAY, 32'd30);
    random_phase(200, 40, 2);
    // hold off the receiver so the block backs up
    hold_off_cycles = 3000;
    random_phase(20, 40, 2);
    calm_phase = 1'b1;
    random_phase(60, 40, 1);
    calm_phase = 1'b0;
    drain();
    write_reg(CFG_BASE, 32'd65535);
    write_reg(CFG_MAX, 32'hFFFF_FFFF);
    write_reg(CFG_BAN, 32'hFFFF_FFFF);
    write_reg(CFG_BANST, 32'd1);
    write_reg(CFG_DECAY, 32'd1);
    random_phase(120, 20, 3);
    drain();
    write_reg(CFG_BASE, 32'd2);
    write_reg(CFG_BANST, 32'd3);
    write_reg(CFG_BAN, 32'd50);
    write_reg(CFG_MAX, 32'd10);
    write_reg(CFG_DECAY, 32'd100000);
    // fill the table past its size so sweeps and untracked verdicts occur
    random_phase(330, 400, 1);
    drain();
    write_reg(CFG_DECAY, 32'd3);
    clock_now = clock_now + 1000;
    random_phase(200, 300, 1);
    drain();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/krl_pkg.sv
rtl/keyed_rate_limiter_with_backoff.sv
tb/tb_keyed_rate_limiter_with_backoff.sv
